// ===== design/nnu_pkg.sv =====
package nnu_pkg;

    localparam int ZOOM_W  = 4;
    localparam int DIM_W   = 13;
    localparam int LINE_W  = 16;
    localparam int INDEX_W = 30;
    localparam int COLOR_W = 32;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // one source pixel, ready for expansion into its square
    typedef struct packed {
        logic [INDEX_W-1:0] base;
        logic [LINE_W-1:0]  line;
        logic [ZOOM_W-1:0]  zoom;
        logic [COLOR_W-1:0] color;
    } t_job;

endpackage

// ===== design/nearest_neighbor_upscaler.sv =====
// The first write beat of a pixel reaches the result side through the front stage
// register, the job queue, the expansion job register and the output register; the rest
// follow one per cycle when pop is held. The expansion unit issues one destination write per
// cycle when pop is held, a pixel's zoom x zoom writes in turn; while the front stage and
// the two-entry job queue have room a pixel is accepted every cycle.
// Reset (synchronous, active low): counters cleared, queues emptied, configuration registers at 1.
module nearest_neighbor_upscaler #(
    parameter int MAX_ZOOM   = 8,
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [nnu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nnu_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [nnu_pkg::COLOR_W-1:0]   i_pixel_color,
    output logic                          empty,
    input  logic                          pop,
    output logic [nnu_pkg::INDEX_W-1:0]   o_dest_index,
    output logic [nnu_pkg::COLOR_W-1:0]   o_out_color,
    output logic                          o_run_last
);

    logic          front_valid;
    nnu_pkg::t_job front_job;
    logic          q_full;
    logic          q_rd;
    logic          q_valid;
    nnu_pkg::t_job q_job;

    nnu_front #(
        .MAX_ZOOM   (MAX_ZOOM),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_pixel_color (i_pixel_color),
        .o_full        (full),
        .o_job_valid   (front_valid),
        .o_job         (front_job),
        .i_job_full    (q_full)
    );

    nnu_queue #(
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_valid),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    nnu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (q_job),
        .o_job_rd     (q_rd),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_dest_index (o_dest_index),
        .o_out_color  (o_out_color),
        .o_run_last   (o_run_last)
    );

endmodule

// ===== design/nnu_front.sv =====
module nnu_front #(
    parameter int MAX_ZOOM   = 8,
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [nnu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nnu_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_push,
    input  logic [nnu_pkg::COLOR_W-1:0]   i_pixel_color,
    output logic                          o_full,
    output logic                          o_job_valid,
    output nnu_pkg::t_job                 o_job,
    input  logic                          i_job_full
);

    localparam int DIM_MAX = (1 << nnu_pkg::DIM_W) - 1;
    localparam int W_LIM = (MAX_WIDTH  > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
    localparam int H_LIM = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
    localparam int CW = (W_LIM > 1) ? $clog2(W_LIM) : 1;
    localparam int CH = (H_LIM > 1) ? $clog2(H_LIM) : 1;
    localparam int RZ_W = CH + nnu_pkg::ZOOM_W;
    localparam int CZ_W = CW + nnu_pkg::ZOOM_W;
    localparam int IW = nnu_pkg::INDEX_W;

    logic [nnu_pkg::ZOOM_W-1:0] r_zoom_reg;
    logic [nnu_pkg::DIM_W-1:0]  r_width_reg;
    logic [nnu_pkg::DIM_W-1:0]  r_height_reg;
    logic [CW-1:0]              r_col;
    logic [CW-1:0]              n_col;
    logic [CH-1:0]              r_row;
    logic [CH-1:0]              n_row;

    logic                       r_a_valid;
    logic [nnu_pkg::LINE_W-1:0] r_a_line;
    logic [RZ_W-1:0]            r_a_rz;
    logic [CZ_W-1:0]            r_a_cz;
    logic [nnu_pkg::ZOOM_W-1:0] r_a_zoom;
    logic [nnu_pkg::COLOR_W-1:0] r_a_color;

    logic [nnu_pkg::ZOOM_W-1:0] z_eff;
    logic [nnu_pkg::DIM_W-1:0]  w_eff;
    logic [nnu_pkg::DIM_W-1:0]  h_eff;
    logic                       accept;
    logic                       a_advance;

    always_comb begin
        if (r_zoom_reg == '0) begin
            z_eff = nnu_pkg::ZOOM_W'(1);
        end else if (32'(r_zoom_reg) > 32'(MAX_ZOOM)) begin
            z_eff = nnu_pkg::ZOOM_W'(MAX_ZOOM);
        end else begin
            z_eff = r_zoom_reg;
        end
        if (r_width_reg == '0) begin
            w_eff = nnu_pkg::DIM_W'(1);
        end else if (32'(r_width_reg) > 32'(W_LIM)) begin
            w_eff = nnu_pkg::DIM_W'(W_LIM);
        end else begin
            w_eff = r_width_reg;
        end
        if (r_height_reg == '0) begin
            h_eff = nnu_pkg::DIM_W'(1);
        end else if (32'(r_height_reg) > 32'(H_LIM)) begin
            h_eff = nnu_pkg::DIM_W'(H_LIM);
        end else begin
            h_eff = r_height_reg;
        end
    end

    assign a_advance = !r_a_valid || !i_job_full;
    assign o_full    = !a_advance;
    assign accept    = i_push && a_advance;

    // wrap when the counter reaches the bound, even one already past it
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if ((14'(r_col) + 14'd1) >= 14'(w_eff)) begin
                n_col = '0;
                if ((14'(r_row) + 14'd1) >= 14'(h_eff)) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + CH'(1);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom_reg   <= nnu_pkg::ZOOM_W'(1);
            r_width_reg  <= nnu_pkg::DIM_W'(1);
            r_height_reg <= nnu_pkg::DIM_W'(1);
            r_col        <= '0;
            r_row        <= '0;
            r_a_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    nnu_pkg::REG_ZOOM:   r_zoom_reg   <= i_cfg_data[nnu_pkg::ZOOM_W-1:0];
                    nnu_pkg::REG_WIDTH:  r_width_reg  <= i_cfg_data;
                    nnu_pkg::REG_HEIGHT: r_height_reg <= i_cfg_data;
                    default: ;
                endcase
            end
            r_col <= n_col;
            r_row <= n_row;
            if (a_advance) begin
                r_a_valid <= i_push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_line  <= nnu_pkg::LINE_W'(w_eff) * nnu_pkg::LINE_W'(z_eff);
            r_a_rz    <= RZ_W'(r_row) * RZ_W'(z_eff);
            r_a_cz    <= CZ_W'(r_col) * CZ_W'(z_eff);
            r_a_zoom  <= z_eff;
            r_a_color <= i_pixel_color;
        end
    end

    // index is kept modulo 2^30, so a truncated product is exact
    assign o_job_valid = r_a_valid;
    assign o_job.base  = (IW'(r_a_rz) * IW'(r_a_line)) + IW'(r_a_cz);
    assign o_job.line  = r_a_line;
    assign o_job.zoom  = r_a_zoom;
    assign o_job.color = r_a_color;

endmodule

// ===== design/nnu_queue.sv =====
module nnu_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  nnu_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_valid,
    output nnu_pkg::t_job o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    nnu_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          do_wr;
    logic          do_rd;

    assign o_full  = (32'(r_count) == 32'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (32'(r_wr_ptr) == DEPTH - 1) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (32'(r_rd_ptr) == DEPTH - 1) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + NW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/nnu_back.sv =====
module nnu_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  nnu_pkg::t_job                i_job,
    output logic                         o_job_rd,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic [nnu_pkg::INDEX_W-1:0]  o_dest_index,
    output logic [nnu_pkg::COLOR_W-1:0]  o_out_color,
    output logic                         o_run_last
);

    localparam int IW = nnu_pkg::INDEX_W;
    localparam int ZW = nnu_pkg::ZOOM_W;

    logic                        r_busy;
    nnu_pkg::t_job               r_job;
    logic [ZW-1:0]               r_dx;
    logic [ZW-1:0]               r_dy;
    logic [IW-1:0]               r_row_addr;
    logic                        r_out_valid;
    logic [IW-1:0]               r_out_index;
    logic [nnu_pkg::COLOR_W-1:0] r_out_color;
    logic                        r_out_last;

    logic          out_ready;
    logic          emit;
    logic          dx_end;
    logic          dy_end;
    logic          square_done;
    logic          load;

    assign out_ready   = !r_out_valid || i_pop;
    assign emit        = r_busy && out_ready;
    assign dx_end      = (r_dx == r_job.zoom - ZW'(1));
    assign dy_end      = (r_dy == r_job.zoom - ZW'(1));
    assign square_done = emit && dx_end && dy_end;
    // take the next pixel in the same cycle the current square ends
    assign load        = i_job_valid && (!r_busy || square_done);
    assign o_job_rd    = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (square_done) begin
                r_busy <= 1'b0;
            end
            if (out_ready) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job      <= i_job;
            r_dx       <= '0;
            r_dy       <= '0;
            r_row_addr <= i_job.base;
        end else if (emit) begin
            if (dx_end) begin
                r_dx       <= '0;
                r_dy       <= r_dy + ZW'(1);
                r_row_addr <= r_row_addr + IW'(r_job.line);
            end else begin
                r_dx <= r_dx + ZW'(1);
            end
        end
        if (emit) begin
            r_out_index <= r_row_addr + IW'(r_dx);
            r_out_color <= r_job.color;
            r_out_last  <= dx_end && dy_end;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_dest_index = r_out_index;
    assign o_out_color  = r_out_color;
    assign o_run_last   = r_out_last;

endmodule

// ===== tb/nearest_neighbor_upscaler_tb.sv =====
`timescale 1ns / 1ps

module nearest_neighbor_upscaler_tb;

    localparam int MAX_ZOOM    = 8;
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 270;
    localparam int CLIMB_ROWS  = 48;

    localparam logic [nnu_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic {STEP_CFG, STEP_PIXEL} t_step_kind;

    typedef struct packed {
        t_step_kind                    kind;
        logic [nnu_pkg::CFG_IDX_W-1:0] sel;
        logic [nnu_pkg::DIM_W-1:0]     value;
        logic [nnu_pkg::COLOR_W-1:0]   color;
        logic                          fixed;
        logic [nnu_pkg::INDEX_W-1:0]   index;
    } t_step;

    typedef struct packed {
        logic [nnu_pkg::INDEX_W-1:0] index;
        logic [nnu_pkg::COLOR_W-1:0] color;
        logic                        run_last;
    } t_write;

    // fixed rows run at zoom 1, so the index can be read straight off the counters
    localparam t_step DIRECTED [32] = '{
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'h0000_0000, 1'b1, 30'd0},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'hFFFF_FFFF, 1'b1, 30'd0},
        '{STEP_CFG,   REG_SPARE,           13'h1FFF, 32'h0000_0000, 1'b0, 30'd0},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'hA5A5_A5A5, 1'b1, 30'd0},
        '{STEP_CFG,   nnu_pkg::REG_WIDTH,  13'h0003, 32'h0000_0000, 1'b0, 30'd0},
        '{STEP_CFG,   nnu_pkg::REG_HEIGHT, 13'h0002, 32'h0000_0000, 1'b0, 30'd0},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'h5A5A_5A5A, 1'b1, 30'd0},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'h0000_00FF, 1'b1, 30'd1},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'h0000_FF00, 1'b1, 30'd2},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'h00FF_0000, 1'b1, 30'd3},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'hFF00_0000, 1'b1, 30'd4},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'h8000_0001, 1'b1, 30'd5},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'h7FFF_FFFE, 1'b1, 30'd0},
        '{STEP_CFG,   nnu_pkg::REG_ZOOM,   13'h0000, 32'h0000_0000, 1'b0, 30'd0},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'h1234_5678, 1'b1, 30'd1},
        '{STEP_CFG,   nnu_pkg::REG_ZOOM,   13'h0002, 32'h0000_0000, 1'b0, 30'd0},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'h89AB_CDEF, 1'b0, 30'd0},
        '{STEP_CFG,   nnu_pkg::REG_ZOOM,   13'h0008, 32'h0000_0000, 1'b0, 30'd0},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'hDEAD_BEEF, 1'b0, 30'd0},
        '{STEP_CFG,   nnu_pkg::REG_ZOOM,   13'h1FF9, 32'h0000_0000, 1'b0, 30'd0},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'h0F0F_0F0F, 1'b0, 30'd0},
        '{STEP_CFG,   nnu_pkg::REG_WIDTH,  13'h0000, 32'h0000_0000, 1'b0, 30'd0},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'hF0F0_F0F0, 1'b0, 30'd0},
        '{STEP_CFG,   nnu_pkg::REG_WIDTH,  13'h1FFF, 32'h0000_0000, 1'b0, 30'd0},
        '{STEP_CFG,   nnu_pkg::REG_HEIGHT, 13'h0000, 32'h0000_0000, 1'b0, 30'd0},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'h3333_CCCC, 1'b0, 30'd0},
        '{STEP_CFG,   nnu_pkg::REG_ZOOM,   13'h0003, 32'h0000_0000, 1'b0, 30'd0},
        '{STEP_CFG,   nnu_pkg::REG_WIDTH,  13'h0002, 32'h0000_0000, 1'b0, 30'd0},
        '{STEP_CFG,   nnu_pkg::REG_HEIGHT, 13'h1000, 32'h0000_0000, 1'b0, 30'd0},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'h0123_4567, 1'b0, 30'd0},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'hCCCC_3333, 1'b0, 30'd0},
        '{STEP_PIXEL, nnu_pkg::REG_ZOOM,   13'h0000, 32'hFEDC_BA98, 1'b0, 30'd0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [nnu_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [nnu_pkg::DIM_W-1:0]     i_cfg_data = '0;
    logic                          push = 1'b0;
    logic                          full;
    logic [nnu_pkg::COLOR_W-1:0]   i_pixel_color = '0;
    logic                          empty;
    logic                          pop = 1'b0;
    logic [nnu_pkg::INDEX_W-1:0]   o_dest_index;
    logic [nnu_pkg::COLOR_W-1:0]   o_out_color;
    logic                          o_run_last;

    // shadow of the block's registers and raster counters
    logic [nnu_pkg::ZOOM_W-1:0] zoom_reg = 4'd1;
    logic [nnu_pkg::DIM_W-1:0]  width_reg = 13'd1;
    logic [nnu_pkg::DIM_W-1:0]  height_reg = 13'd1;
    int                         col_pos = 0;
    int                         row_pos = 0;

    t_write expected_writes[$];
    t_write head;
    int     mismatches = 0;
    int     quiet_cycles = 0;
    bit     steady = 1'b0;

    nearest_neighbor_upscaler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_pixel_color (i_pixel_color),
        .empty         (empty),
        .pop           (pop),
        .o_dest_index  (o_dest_index),
        .o_out_color   (o_out_color),
        .o_run_last    (o_run_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 21);
    endfunction

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [nnu_pkg::DIM_W-1:0] pick_zoom();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return nnu_pkg::DIM_W'($urandom_range(1, 3));
        if (r < 8) return nnu_pkg::DIM_W'($urandom_range(4, MAX_ZOOM));
        if (r == 8) return nnu_pkg::DIM_W'($urandom_range(0, 15));
        return nnu_pkg::DIM_W'($urandom_range(0, 8191));
    endfunction

    function automatic logic [nnu_pkg::DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return nnu_pkg::DIM_W'($urandom_range(1, 6));
        if (r < 8) return nnu_pkg::DIM_W'($urandom_range(7, 40));
        if (r == 8) return nnu_pkg::DIM_W'($urandom_range(0, 8191));
        return nnu_pkg::DIM_W'(MAX_WIDTH);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // expand one pixel into its zoom x zoom square, then advance the raster position
    task automatic expand_pixel(input logic [nnu_pkg::COLOR_W-1:0] color);
        int z;
        int w;
        int h;
        longint unsigned line;
        longint unsigned addr;
        z = clamp_dim(int'(zoom_reg), MAX_ZOOM);
        w = clamp_dim(int'(width_reg), MAX_WIDTH);
        h = clamp_dim(int'(height_reg), MAX_HEIGHT);
        line = longint'(w) * z;
        for (int dy = 0; dy < z; dy++) begin
            for (int dx = 0; dx < z; dx++) begin
                addr = (longint'(row_pos) * z + dy) * line + longint'(col_pos) * z + dx;
                expected_writes.push_back('{addr[nnu_pkg::INDEX_W-1:0], color,
                                            (dy == z - 1) && (dx == z - 1)});
            end
        end
        // a counter already past a shrunken bound wraps on this advance
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 >= h)
                row_pos = 0;
            else
                row_pos++;
        end else begin
            col_pos++;
        end
    endtask

    task automatic send_pixel(input logic [nnu_pkg::COLOR_W-1:0] color);
        while (take_break()) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_pixel_color <= color;
        do @(posedge i_clk); while (full);
        expand_pixel(color);
    endtask

    task automatic write_reg(input logic [nnu_pkg::CFG_IDX_W-1:0] sel,
                             input logic [nnu_pkg::DIM_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (sel)
            nnu_pkg::REG_ZOOM:   zoom_reg = value[nnu_pkg::ZOOM_W-1:0];
            nnu_pkg::REG_WIDTH:  width_reg = value;
            nnu_pkg::REG_HEIGHT: height_reg = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // drop push and wait until every write in flight has been drained
    task automatic settle();
        push <= 1'b0;
        while (expected_writes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= !take_break();
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected write index=%0d color=%h",
                                          o_dest_index, o_out_color));
            end else begin
                head = expected_writes.pop_front();
                if (o_dest_index !== head.index)
                    report_mismatch($sformatf("dest_index got %0d want %0d",
                                              o_dest_index, head.index));
                if (o_out_color !== head.color)
                    report_mismatch($sformatf("out_color got %h want %h at index %0d",
                                              o_out_color, head.color, head.index));
                if (o_run_last !== head.run_last)
                    report_mismatch($sformatf("run_last got %b want %b at index %0d",
                                              o_run_last, head.run_last, head.index));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase;
        int sent;
        int n;
        phase = 0;
        sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == STEP_CFG) begin
                settle();
                write_reg(DIRECTED[i].sel, DIRECTED[i].value);
            end else begin
                send_pixel(DIRECTED[i].color);
                if (DIRECTED[i].fixed)
                    expected_writes[expected_writes.size() - 1].index = DIRECTED[i].index;
            end
        end

        // climb the row counter, then expand on the widest line at the largest zoom
        settle();
        write_reg(nnu_pkg::REG_ZOOM, 13'd1);
        write_reg(nnu_pkg::REG_WIDTH, 13'd1);
        write_reg(nnu_pkg::REG_HEIGHT, 13'd1);
        send_pixel($urandom);
        settle();
        write_reg(nnu_pkg::REG_HEIGHT, nnu_pkg::DIM_W'(MAX_HEIGHT));
        repeat (CLIMB_ROWS) send_pixel($urandom);
        settle();
        write_reg(nnu_pkg::REG_WIDTH, nnu_pkg::DIM_W'(MAX_WIDTH));
        write_reg(nnu_pkg::REG_ZOOM, nnu_pkg::DIM_W'(MAX_ZOOM));
        repeat (2) send_pixel($urandom);

        // skipped writes leave the counters mid-frame across the new setting
        while (sent < RANDOM_ITEMS) begin
            settle();
            steady = (phase >= 4) && (phase < 8);
            if ($urandom_range(0, 9) < 7) write_reg(nnu_pkg::REG_ZOOM, pick_zoom());
            if ($urandom_range(0, 9) < 6) write_reg(nnu_pkg::REG_WIDTH, pick_dim());
            if ($urandom_range(0, 9) < 6) write_reg(nnu_pkg::REG_HEIGHT, pick_dim());
            if ($urandom_range(0, 6) == 0)
                write_reg(REG_SPARE, nnu_pkg::DIM_W'($urandom_range(0, 8191)));
            n = $urandom_range(8, 30);
            repeat (n) send_pixel($urandom);
            sent += n;
            phase++;
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/nnu_pkg.sv
design/nnu_front.sv
design/nnu_queue.sv
design/nnu_back.sv
design/nearest_neighbor_upscaler.sv
tb/nearest_neighbor_upscaler_tb.sv
